// ===== src/xorshift64star_range_rng_defines.svh =====
// ---------------------------------------------------------------------------
// xorshift64star_range_rng assertion macros
// Shared concurrent assertion forms for the generator's checker.
// ---------------------------------------------------------------------------
`ifndef XORSHIFT64STAR_RANGE_RNG_DEFINES_SVH
`define XORSHIFT64STAR_RANGE_RNG_DEFINES_SVH

// checked outside reset only
`define XRNG_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("xrng checker: property failed");

// checked on every edge, reset included
`define XRNG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("xrng checker: property failed during or after reset");

`endif

// ===== src/xrng_pkg.sv =====
// ---------------------------------------------------------------------------
// xrng_pkg
// Types and constants of the xorshift64* range generator.
// ---------------------------------------------------------------------------
package xrng_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ACT_W   = 2;

    localparam logic [STATE_W-1:0] RESET_STATE = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [STATE_W-1:0] MIX_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam logic [STATE_W-1:0] MIX_MULT3   = MIX_MULT + (MIX_MULT << 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_SEED    = 2'd0,
        ACT_RAW     = 2'd1,
        ACT_BELOW   = 2'd2,
        ACT_BETWEEN = 2'd3
    } t_action;

endpackage

// ===== src/xorshift64star_range_rng.sv =====
// Steps: a raw draw loads the request, then runs 32 radix-4 multiply steps; a ranged draw
//   runs 32 more bit-serial remainder steps; an empty range skips both; seed gives no result.
// Requests: taken one at a time, through the shared shift-add multiplier and the restoring
//   remainder unit, which run one after the other; the next is taken once the result has
//   moved to the output register.
// Reset: synchronous, active low; state returns to 0x9E3779B97F4A7C15, no result pending.
// ---------------------------------------------------------------------------
// xorshift64star_range_rng
// xorshift64* generator with seed, raw, below-bound and between-bounds draws.
// ---------------------------------------------------------------------------
module xorshift64star_range_rng
    import xrng_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,  // seed_value[31:0], bound_low[63:32], bound_high[95:64]
    input  logic [1:0]  i_s_axis_tuser,  // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // value[31:0]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_fsm;

    t_fsm                 r_fsm;
    logic [STATE_W-1:0]   r_state;
    logic [STATE_W-1:0]   r_mul_s;
    logic [STATE_W-1:0]   r_mc;
    logic [STATE_W-1:0]   r_mc3;
    logic [STATE_W-1:0]   r_acc;
    logic [WORD_W-1:0]    r_div;
    logic [WORD_W-1:0]    r_rem;
    logic [WORD_W-1:0]    r_span;
    logic [WORD_W-1:0]    r_base;
    logic [WORD_W-1:0]    r_res;
    logic [WORD_W-1:0]    r_odata;
    logic [4:0]           r_cnt;
    logic                 r_use_mod;
    logic                 r_ovalid;

    t_action              w_act;
    logic [WORD_W-1:0]    w_seed;
    logic signed [WORD_W-1:0] w_lo;
    logic signed [WORD_W-1:0] w_hi;
    logic [STATE_W-1:0]   w_xs1;
    logic [STATE_W-1:0]   w_xs2;
    logic [STATE_W-1:0]   w_xs;
    logic [STATE_W-1:0]   w_pp;
    logic [STATE_W-1:0]   n_acc;
    logic [WORD_W:0]      w_trial;
    logic [WORD_W-1:0]    n_rem;
    logic                 w_accept;
    logic                 w_out_free;

    assign w_act  = t_action'(i_s_axis_tuser);
    assign w_seed = i_s_axis_tdata[31:0];
    assign w_lo   = i_s_axis_tdata[63:32];
    assign w_hi   = i_s_axis_tdata[95:64];

    assign w_xs1 = r_state ^ (r_state >> 12);
    assign w_xs2 = w_xs1 ^ (w_xs1 << 25);
    assign w_xs  = w_xs2 ^ (w_xs2 >> 27);

    // radix-4 digit of the state times the shifted constant
    always_comb begin
        case (r_mul_s[1:0])
            2'd0:    w_pp = '0;
            2'd1:    w_pp = r_mc;
            2'd2:    w_pp = r_mc << 1;
            2'd3:    w_pp = r_mc3;
            default: w_pp = '0;
        endcase
    end
    assign n_acc = r_acc + w_pp;

    // restoring remainder step
    assign w_trial = {r_rem, r_div[WORD_W-1]};
    assign n_rem   = (w_trial >= {1'b0, r_span}) ? WORD_W'(w_trial - {1'b0, r_span})
                                                  : w_trial[WORD_W-1:0];

    assign o_s_axis_tready = (r_fsm == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_IDLE;
            r_state  <= RESET_STATE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if ((r_fsm == ST_FIN) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_fsm)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_acc     <= '0;
                        r_mc      <= MIX_MULT;
                        r_mc3     <= MIX_MULT3;
                        r_mul_s   <= w_xs;
                        r_cnt     <= '0;
                        r_base    <= (w_act == ACT_BETWEEN) ? w_lo : '0;
                        r_span    <= (w_act == ACT_BETWEEN) ? WORD_W'(w_hi - w_lo) : w_hi;
                        r_use_mod <= (w_act != ACT_RAW);
                        case (w_act)
                            ACT_SEED: begin
                                r_state <= (w_seed == '0) ? STATE_W'(1)
                                                          : {{WORD_W{1'b0}}, w_seed};
                            end
                            ACT_RAW: begin
                                r_state   <= w_xs;
                                r_fsm     <= ST_MUL;
                            end
                            ACT_BELOW: begin
                                if (w_hi <= 0) begin
                                    r_res <= '0;
                                    r_fsm <= ST_FIN;
                                end else begin
                                    r_state <= w_xs;
                                    r_fsm   <= ST_MUL;
                                end
                            end
                            ACT_BETWEEN: begin
                                if (w_hi <= w_lo) begin
                                    r_res <= w_lo;
                                    r_fsm <= ST_FIN;
                                end else begin
                                    r_state <= w_xs;
                                    r_fsm   <= ST_MUL;
                                end
                            end
                            default: begin
                                r_fsm <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_acc   <= n_acc;
                    r_mul_s <= r_mul_s >> 2;
                    r_mc    <= r_mc << 2;
                    r_mc3   <= r_mc3 << 2;
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == '1) begin
                        if (r_use_mod) begin
                            r_div <= n_acc[STATE_W-1:WORD_W];
                            r_rem <= '0;
                            r_fsm <= ST_DIV;
                        end else begin
                            r_res <= n_acc[STATE_W-1:WORD_W];
                            r_fsm <= ST_FIN;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_div <= r_div << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == '1) begin
                        r_res <= r_base + n_rem;
                        r_fsm <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_odata  <= r_res;
                        r_fsm    <= ST_IDLE;
                    end
                end
                default: begin
                    r_fsm <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/xrng_checker.sv =====
// ---------------------------------------------------------------------------
// xrng_checker
// Port-level checks of the xorshift64* range generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "xorshift64star_range_rng_defines.svh"

module xrng_checker
    import xrng_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic [1:0] i_s_tuser,
    input logic       i_m_tvalid,
    input logic       i_m_tready
);

    logic w_in_xfer;

    assign w_in_xfer = i_s_tvalid && i_s_tready;

    // a result never shows in the cycle straight after a transfer in
    `XRNG_ASSERT(a_no_early_result, w_in_xfer |=> !$rose(i_m_tvalid))
    // any drawing request keeps the input closed while it is worked on
    `XRNG_ASSERT(a_busy_after_draw,
        (w_in_xfer && (i_s_tuser != ACT_SEED)) |=> !i_s_tready)
    // a pending result holds until taken
    `XRNG_ASSERT(a_out_hold, (i_m_tvalid && !i_m_tready) |=> i_m_tvalid)
    // reset leaves nothing pending and the input open
    `XRNG_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (!i_m_tvalid && i_s_tready))

endmodule

bind xorshift64star_range_rng xrng_checker u_xrng_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tuser  (i_s_axis_tuser),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready)
);
